// ----- hw/rtl/sbadu_pkg.sv -----
// ----------------------------------------------------------------------------
// sbadu_pkg
// Shared types and constants for the signed byte ALU with Booth multiply and
// restoring divide.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sbadu_pkg;

  localparam int OPW     = 8;
  localparam int RES_W   = 16;
  localparam int STEPS   = OPW;
  localparam int CNT_W   = $clog2(STEPS + 1);

  typedef enum logic [1:0] {
    CMD_ADD = 2'd0,
    CMD_SUB = 2'd1,
    CMD_MUL = 2'd2,
    CMD_DIV = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic store;
  } dp_cmd_t;

  typedef struct packed {
    logic short_op;
  } dp_status_t;

endpackage

`default_nettype wire

// ----- hw/rtl/signed_byte_alu_booth_divide_unit.sv -----
// ----------------------------------------------------------------------------
// signed_byte_alu_booth_divide_unit
// Signed 8-bit ALU: wrapping add and subtract, radix-2 Booth multiply and
// restoring divide with sign fix-up.
// ----------------------------------------------------------------------------
// Channel | Handshake             | Payload
// in      | in_valid / in_ready   | cmd, operand_a, operand_b
// out     | out_valid / out_ready | result_value, remainder_value, divide_by_zero
//
// Add, subtract and a divide by zero go from accept straight to store; multiply
// and any other divide run eight shift-add steps on the shared accumulator
// between accept and store.
// One beat is in work at a time; a new beat is accepted while the previous
// result still waits in the output register.
// A stalled output holds the finished beat in the datapath until the output
// register frees up. Reset is synchronous and clears the control state only.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module signed_byte_alu_booth_divide_unit
  import sbadu_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [1:0]            cmd,
  input  wire logic signed [OPW-1:0] operand_a,
  input  wire logic signed [OPW-1:0] operand_b,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic signed [RES_W-1:0]    result_value,
  output logic signed [OPW-1:0]      remainder_value,
  output logic                       divide_by_zero
);

  dp_cmd_t    dp_cmd;
  dp_status_t status;

  sbadu_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .dp_cmd    (dp_cmd)
  );

  sbadu_dp u_dp (
    .clk             (clk),
    .dp_cmd          (dp_cmd),
    .status          (status),
    .cmd             (cmd),
    .operand_a       (operand_a),
    .operand_b       (operand_b),
    .result_value    (result_value),
    .remainder_value (remainder_value),
    .divide_by_zero  (divide_by_zero)
  );

endmodule

`default_nettype wire

// ----- hw/rtl/sbadu_ctrl.sv -----
// ----------------------------------------------------------------------------
// sbadu_ctrl
// Controller: accepts a beat, sequences the shift-add steps and hands the
// result to the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sbadu_ctrl
  import sbadu_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  wire logic       out_ready,
  input  wire dp_status_t status,
  output dp_cmd_t         dp_cmd
);

  state_t           state;
  state_t           state_next;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             out_valid_next;
  logic             finished;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      out_valid <= out_valid_next;
    end
  end

  assign finished = status.short_op || (count == CNT_W'(STEPS));

  always_comb begin
    state_next     = state;
    count_next     = count;
    out_valid_next = out_valid && !out_ready;
    in_ready       = 1'b0;
    dp_cmd         = '0;
    unique case (state)
      ST_IDLE: begin
        in_ready = !rst;
        if (in_valid && !rst) begin
          dp_cmd.load = 1'b1;
          count_next  = '0;
          state_next  = ST_RUN;
        end
      end
      ST_RUN: begin
        if (finished) begin
          if (!out_valid || out_ready) begin
            dp_cmd.store   = 1'b1;
            out_valid_next = 1'b1;
            state_next     = ST_IDLE;
          end
        end else begin
          dp_cmd.step = 1'b1;
          count_next  = count + CNT_W'(1);
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- hw/rtl/sbadu_dp.sv -----
// ----------------------------------------------------------------------------
// sbadu_dp
// Datapath: operand registers, shared accumulator for Booth steps and
// restoring division steps, sign fix-up and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sbadu_dp
  import sbadu_pkg::*;
(
  input  wire logic                    clk,
  input  wire dp_cmd_t                 dp_cmd,
  output dp_status_t                   status,
  input  wire logic [1:0]              cmd,
  input  wire logic signed [OPW-1:0]   operand_a,
  input  wire logic signed [OPW-1:0]   operand_b,
  output logic signed [RES_W-1:0]      result_value,
  output logic signed [OPW-1:0]        remainder_value,
  output logic                         divide_by_zero
);

  cmd_t           op;
  logic           na;
  logic           nb;
  logic           dz;
  logic [OPW:0]   acc;
  logic [OPW-1:0] qreg;
  logic           qm1;
  logic [OPW:0]   mreg;

  logic [OPW:0]   booth_sum;
  logic [OPW:0]   rem_shift;
  logic [OPW+1:0] trial;
  logic [OPW-1:0] short_sum;
  logic [OPW-1:0] quot_fix;
  logic [OPW-1:0] rem_fix;
  logic [OPW-1:0] mag_a;
  logic [OPW:0]   mag_b;

  assign mag_a = operand_a[OPW-1] ? OPW'(-operand_a) : operand_a;
  assign mag_b = operand_b[OPW-1] ? (OPW+1)'(-{operand_b[OPW-1], operand_b})
                                  : {1'b0, operand_b};

  always_comb begin
    case ({qreg[0], qm1})
      2'b01:   booth_sum = acc + mreg;
      2'b10:   booth_sum = acc - mreg;
      default: booth_sum = acc;
    endcase
  end

  assign rem_shift = {acc[OPW-1:0], qreg[OPW-1]};
  assign trial     = {1'b0, rem_shift} - {1'b0, mreg};

  assign short_sum = (op == CMD_SUB) ? mreg[OPW-1:0] - qreg : mreg[OPW-1:0] + qreg;
  assign quot_fix  = (na ^ nb) ? OPW'(-qreg) : qreg;
  assign rem_fix   = na ? OPW'(-acc[OPW-1:0]) : acc[OPW-1:0];

  assign status.short_op = (op == CMD_ADD) || (op == CMD_SUB) || dz;

  always_ff @(posedge clk) begin
    if (dp_cmd.load) begin
      op  <= cmd_t'(cmd);
      na  <= operand_a[OPW-1];
      nb  <= operand_b[OPW-1];
      dz  <= (cmd_t'(cmd) == CMD_DIV) && (operand_b == '0);
      acc <= '0;
      qm1 <= 1'b0;
      if (cmd_t'(cmd) == CMD_DIV) begin
        mreg <= mag_b;
        qreg <= mag_a;
      end else begin
        mreg <= {operand_a[OPW-1], operand_a};
        qreg <= operand_b;
      end
    end else if (dp_cmd.step) begin
      if (op == CMD_MUL) begin
        {acc, qreg, qm1} <= {booth_sum[OPW], booth_sum, qreg};
      end else if (!trial[OPW+1]) begin
        acc  <= trial[OPW:0];
        qreg <= {qreg[OPW-2:0], 1'b1};
      end else begin
        acc  <= rem_shift;
        qreg <= {qreg[OPW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.store) begin
      remainder_value <= '0;
      divide_by_zero  <= 1'b0;
      unique case (op) inside
        CMD_ADD, CMD_SUB: begin
          result_value <= RES_W'(signed'(short_sum));
        end
        CMD_MUL: begin
          result_value <= RES_W'({acc[OPW-1:0], qreg});
        end
        CMD_DIV: begin
          if (dz) begin
            result_value   <= '0;
            divide_by_zero <= 1'b1;
          end else begin
            result_value    <= RES_W'(signed'(quot_fix));
            remainder_value <= rem_fix;
          end
        end
        default: begin
          result_value <= '0;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- bench/signed_byte_alu_booth_divide_unit_test.sv -----
// ----------------------------------------------------------------------------
// signed_byte_alu_booth_divide_unit_test
// Self-checking bench for the signed byte ALU. A short table of corner-case
// operations runs first, then about 1650 random beats with extreme operand
// values mixed in. Every result is checked field by field against its table
// entry, where one is given, or else a behavioral model of wrapping add and
// subtract, full signed multiply and sign-corrected division. The sender runs
// in random bursts, and the receiver stalls in changing patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module signed_byte_alu_booth_divide_unit_test;
  import sbadu_pkg::*;

  localparam int N_DIRECTED  = 25;
  localparam int N_RANDOM    = 1650;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 30;

  typedef struct packed {
    logic signed [RES_W-1:0] res;
    logic signed [OPW-1:0]   rem;
    logic                    dz;
  } alu_out_t;

  typedef struct packed {
    cmd_t           op;
    logic [OPW-1:0] a;
    logic [OPW-1:0] b;
    logic           known;
    alu_out_t       want;
  } dir_row_t;

  logic                    clk;
  logic                    rst;
  logic                    in_valid;
  logic                    in_ready;
  cmd_t                    cmd;
  logic signed [OPW-1:0]   operand_a;
  logic signed [OPW-1:0]   operand_b;
  logic                    out_valid;
  logic                    out_ready;
  logic signed [RES_W-1:0] result_value;
  logic signed [OPW-1:0]   remainder_value;
  logic                    divide_by_zero;

  alu_out_t pending_results[$];
  int       mismatches = 0;
  int       results_checked = 0;
  int       cycles = 0;
  int       op_beats[4] = '{0, 0, 0, 0};
  int       zero_divisors = 0;
  int       burst_left = 1;

  dir_row_t directed_rows [0:N_DIRECTED-1] = '{
    '{CMD_ADD, 8'h7F, 8'h01, 1'b1, '{16'hFF80, 8'h00, 1'b0}},
    '{CMD_ADD, 8'h80, 8'h80, 1'b1, '{16'h0000, 8'h00, 1'b0}},
    '{CMD_ADD, 8'hFF, 8'h01, 1'b0, '0},
    '{CMD_ADD, 8'h00, 8'h00, 1'b0, '0},
    '{CMD_SUB, 8'h80, 8'h01, 1'b1, '{16'h007F, 8'h00, 1'b0}},
    '{CMD_SUB, 8'h7F, 8'hFF, 1'b1, '{16'hFF80, 8'h00, 1'b0}},
    '{CMD_SUB, 8'h00, 8'h80, 1'b1, '{16'hFF80, 8'h00, 1'b0}},
    '{CMD_SUB, 8'hFF, 8'hFF, 1'b0, '0},
    '{CMD_MUL, 8'h80, 8'h80, 1'b1, '{16'h4000, 8'h00, 1'b0}},
    '{CMD_MUL, 8'h7F, 8'h80, 1'b1, '{16'hC080, 8'h00, 1'b0}},
    '{CMD_MUL, 8'h7F, 8'h7F, 1'b1, '{16'h3F01, 8'h00, 1'b0}},
    '{CMD_MUL, 8'h00, 8'h80, 1'b1, '{16'h0000, 8'h00, 1'b0}},
    '{CMD_MUL, 8'hFF, 8'h01, 1'b0, '0},
    '{CMD_DIV, 8'h05, 8'h00, 1'b1, '{16'h0000, 8'h00, 1'b1}},
    '{CMD_DIV, 8'h80, 8'h00, 1'b1, '{16'h0000, 8'h00, 1'b1}},
    '{CMD_DIV, 8'h80, 8'hFF, 1'b1, '{16'hFF80, 8'h00, 1'b0}},
    '{CMD_DIV, 8'h80, 8'h80, 1'b1, '{16'h0001, 8'h00, 1'b0}},
    '{CMD_DIV, 8'h7F, 8'h80, 1'b1, '{16'h0000, 8'h7F, 1'b0}},
    '{CMD_DIV, 8'h81, 8'h80, 1'b1, '{16'h0000, 8'h81, 1'b0}},
    '{CMD_DIV, 8'h80, 8'h01, 1'b1, '{16'hFF80, 8'h00, 1'b0}},
    '{CMD_DIV, 8'h7F, 8'h7F, 1'b1, '{16'h0001, 8'h00, 1'b0}},
    '{CMD_DIV, 8'hF9, 8'h02, 1'b0, '0},
    '{CMD_DIV, 8'h07, 8'hFE, 1'b0, '0},
    '{CMD_DIV, 8'hF9, 8'hFE, 1'b0, '0},
    '{CMD_DIV, 8'h80, 8'h03, 1'b0, '0}
  };

  signed_byte_alu_booth_divide_unit i_dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .cmd             (cmd),
    .operand_a       (operand_a),
    .operand_b       (operand_b),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .result_value    (result_value),
    .remainder_value (remainder_value),
    .divide_by_zero  (divide_by_zero)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic alu_out_t alu_outcome(cmd_t op, logic signed [OPW-1:0] a,
                                           logic signed [OPW-1:0] b);
    alu_out_t              o;
    int                    sa;
    int                    sb;
    int                    quo;
    int                    rmd;
    logic signed [OPW-1:0] wrapped;
    o  = '0;
    sa = int'(a);
    sb = int'(b);
    case (op)
      CMD_ADD: begin
        wrapped = OPW'(sa + sb);
        o.res   = RES_W'(wrapped);
      end
      CMD_SUB: begin
        wrapped = OPW'(sa - sb);
        o.res   = RES_W'(wrapped);
      end
      CMD_MUL: begin
        o.res = RES_W'(sa * sb);
      end
      default: begin
        if (sb == 0) begin
          o.dz = 1'b1;
        end else begin
          quo = (sa < 0 ? -sa : sa) / (sb < 0 ? -sb : sb);
          rmd = (sa < 0 ? -sa : sa) % (sb < 0 ? -sb : sb);
          if ((sa < 0) != (sb < 0)) quo = -quo;
          if (sa < 0) rmd = -rmd;
          wrapped = OPW'(quo);
          o.res   = RES_W'(wrapped);
          o.rem   = OPW'(rmd);
        end
      end
    endcase
    return o;
  endfunction

  function automatic logic [OPW-1:0] pick_operand();
    case ($urandom_range(0, 9))
      0:       return 8'h80;
      1:       return 8'h7F;
      2:       return 8'h00;
      3:       return 8'hFF;
      4:       return 8'h01;
      default: return OPW'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic pace_sender();
    int gap;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 16);
    end
  endtask

  task automatic offer_beat(input cmd_t op, input logic [OPW-1:0] a,
                            input logic [OPW-1:0] b, input logic known,
                            input alu_out_t typed);
    in_valid  <= 1'b1;
    cmd       <= op;
    operand_a <= a;
    operand_b <= b;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(known ? typed : alu_outcome(op, a, b));
    op_beats[op]++;
    if (op == CMD_DIV && b == '0) zero_divisors++;
    pace_sender();
  endtask

  // Receiver stall pattern: always ready, coin flip, long stalls or alternating.
  int ready_mode = 0;
  int mode_left  = 0;
  int phase_cnt  = 0;

  always @(posedge clk) begin
    if (mode_left == 0) begin
      ready_mode = $urandom_range(0, 3);
      mode_left  = $urandom_range(40, 200);
    end else begin
      mode_left--;
    end
    phase_cnt++;
    case (ready_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= 1'($urandom_range(0, 1));
      2:       out_ready <= ($urandom_range(0, 7) == 0);
      default: out_ready <= phase_cnt[0];
    endcase
  end

  always @(posedge clk) begin
    alu_out_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected result beat: res %0d rem %0d dz %0d",
                   result_value, remainder_value, divide_by_zero);
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (want.res !== result_value || want.rem !== remainder_value ||
            want.dz !== divide_by_zero) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"Mismatch on result %0d: expected res %0d rem %0d dz %0d,",
                      " got res %0d rem %0d dz %0d"},
                     results_checked, want.res, want.rem, want.dz,
                     result_value, remainder_value, divide_by_zero);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.",
               cycles, pending_results.size());
      $display("[signed_byte_alu_booth_divide_unit] ERROR");
      $finish;
    end
  end

  initial begin
    rst       = 1'b1;
    in_valid  = 1'b0;
    cmd       = CMD_ADD;
    operand_a = '0;
    operand_b = '0;
    out_ready = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int i = 0; i < N_DIRECTED; i++)
      offer_beat(directed_rows[i].op, directed_rows[i].a, directed_rows[i].b,
                 directed_rows[i].known, directed_rows[i].want);
    for (int i = 0; i < N_RANDOM; i++)
      offer_beat(cmd_t'($urandom_range(0, 3)), pick_operand(), pick_operand(),
                 1'b0, '0);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    $display("Checked %0d results: %0d add, %0d subtract, %0d multiply, %0d divide beats.",
             results_checked, op_beats[CMD_ADD], op_beats[CMD_SUB],
             op_beats[CMD_MUL], op_beats[CMD_DIV]);
    $display("Zero divisors: %0d, mismatches: %0d, cycles: %0d.",
             zero_divisors, mismatches, cycles);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("[signed_byte_alu_booth_divide_unit] OK");
    end else begin
      $display("[signed_byte_alu_booth_divide_unit] ERROR");
    end
    $finish;
  end

endmodule
